// ===== hw/rtl/omr_pkg.sv =====
// omr_pkg: shared types and constants for the orbit minimum representative block.
// Holds the stage word and load structs, the op codes, the FSM states and the
// Benes stage shift function. No dependencies.
package omr_pkg;

	localparam int DATA_W       = 64;
	localparam int ROW_W        = 8;
	localparam int STAGE_W      = 4;
	localparam int GC_W         = 9;
	localparam int NUM_STAGES   = 11;
	localparam int DRAIN_CYCLES = 2 * NUM_STAGES;
	localparam int DRAIN_W      = $clog2(DRAIN_CYCLES + 1);

	localparam logic OP_LOAD  = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_DRAIN
	} omr_state_t;

	// one image on its way down the network
	typedef struct packed {
		logic              valid;
		logic [ROW_W-1:0]  row;
		logic [DATA_W-1:0] data;
	} omr_word_t;

	// mask write broadcast to every cell
	typedef struct packed {
		logic               we;
		logic [STAGE_W-1:0] stage;
		logic [ROW_W-1:0]   row;
		logic [DATA_W-1:0]  word;
	} omr_load_t;

	typedef struct packed {
		logic              start;
		logic [DATA_W-1:0] seed;
	} omr_min_ctl_t;

	// shifts 1,2,4,8,16,32,16,8,4,2,1
	function automatic int stage_shift(input int s);
		int sh;
		if (s < 6) begin
			sh = 1 << s;
		end else begin
			sh = 1 << (10 - s);
		end
		return sh;
	endfunction

endpackage

// ===== hw/rtl/orbit_min_representative.sv =====
// orbit_min_representative: top level, sequencer, cell chain and result register.
// Depends on omr_pkg, omr_cell and omr_min.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one word per handshake. A load
//   word (operation = 0) writes mask_word into row mask_row, stage mask_stage
//   of the permutation table; it gives no result. A query word (operation = 1)
//   reduces state_in over rows 1..group_count-1 (group_count taken as 1 when
//   zero, capped at the table size and at 256). The rows stream through a
//   chain of 11 delta swap cells, one row entering per cycle; each cell reads
//   its own mask memory, then swaps. The input stays stalled until the result
//   is registered, and the next word can be taken as soon as the result appears.
//   The result sits in an output register: while out_stall is high it holds,
//   and the block keeps taking loads and can start one more query, which
//   waits at its end until the register is free.
//   Configuration (cfg_valid / cfg_ready / cfg_data) writes group_count; it is
//   always ready. Reset sets group_count to 1 and empties all channels. The
//   mask memories are not cleared; rows must be loaded before they are used.
module orbit_min_representative #(
	parameter int MAX_GROUP = 256
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic                         operation,
	input  logic [omr_pkg::ROW_W-1:0]    mask_row,
	input  logic [omr_pkg::STAGE_W-1:0]  mask_stage,
	input  logic [omr_pkg::DATA_W-1:0]   mask_word,
	input  logic [omr_pkg::DATA_W-1:0]   state_in,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [omr_pkg::DATA_W-1:0]   representative,
	output logic [omr_pkg::ROW_W-1:0]    group_index,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [omr_pkg::GC_W-1:0]     cfg_data
);
	import omr_pkg::*;

	localparam int CNT_MAX = (MAX_GROUP < 256) ? MAX_GROUP : 256;

	omr_state_t         state_q, state_nxt;
	logic [GC_W-1:0]    group_count_q;
	logic [GC_W-1:0]    count_eff;
	logic [GC_W-1:0]    count_q;
	logic [GC_W-1:0]    row_q;
	logic [DATA_W-1:0]  query_q;
	logic [DRAIN_W-1:0] drain_q;
	logic               in_take;
	logic               query_take;
	logic               issue;
	logic               last_issue;
	logic               finish;
	logic               out_valid_q;
	logic [DATA_W-1:0]  rep_q;
	logic [ROW_W-1:0]   gidx_q;
	logic [DATA_W-1:0]  best;
	logic [ROW_W-1:0]   best_row;
	omr_load_t          load;
	omr_min_ctl_t       min_ctl;
	omr_word_t          link [NUM_STAGES+1];

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			group_count_q <= GC_W'(1);
		end else if (cfg_valid && cfg_ready) begin
			group_count_q <= cfg_data;
		end
	end

	always_comb begin
		if (group_count_q == '0) begin
			count_eff = GC_W'(1);
		end else if (int'(group_count_q) > CNT_MAX) begin
			count_eff = GC_W'(CNT_MAX);
		end else begin
			count_eff = group_count_q;
		end
	end

	// outputs of the sequencer
	always_comb begin
		in_stall   = (state_q != ST_IDLE);
		in_take    = in_valid && !in_stall;
		query_take = in_take && operation == OP_QUERY;
		issue      = (state_q == ST_RUN);
		last_issue = issue && (row_q == count_q - GC_W'(1));
		finish     = (state_q == ST_DRAIN) && (drain_q == DRAIN_W'(DRAIN_CYCLES))
			&& (!out_valid_q || !out_stall);
	end

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (query_take) begin
					state_nxt = (count_eff > GC_W'(1)) ? ST_RUN : ST_DRAIN;
				end
			end
			ST_RUN: begin
				if (last_issue) begin
					state_nxt = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (finish) begin
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			row_q   <= '0;
			drain_q <= '0;
		end else begin
			state_q <= state_nxt;
			if (query_take) begin
				row_q <= GC_W'(1);
			end else if (issue) begin
				row_q <= row_q + GC_W'(1);
			end
			if (state_nxt == ST_DRAIN && state_q != ST_DRAIN) begin
				drain_q <= '0;
			end else if (state_q == ST_DRAIN && drain_q != DRAIN_W'(DRAIN_CYCLES)) begin
				drain_q <= drain_q + DRAIN_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (query_take) begin
			count_q <= count_eff;
			query_q <= state_in;
		end
	end

	// drop loads aimed past the network or past the table
	always_comb begin
		load.we    = in_take && operation == OP_LOAD
			&& int'(mask_stage) < NUM_STAGES && int'(mask_row) < MAX_GROUP;
		load.stage = mask_stage;
		load.row   = mask_row;
		load.word  = mask_word;
	end

	always_comb begin
		link[0].valid = issue;
		link[0].row   = row_q[ROW_W-1:0];
		link[0].data  = query_q;
	end

	for (genvar i = 0; i < NUM_STAGES; i++) begin : g_cell
		omr_cell #(
			.MAX_GROUP (MAX_GROUP),
			.STAGE_IDX (i),
			.SHIFT     (stage_shift(i))
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.load   (load),
			.din    (link[i]),
			.dout   (link[i+1])
		);
	end

	assign min_ctl.start = query_take;
	assign min_ctl.seed  = state_in;

	omr_min u_min (
		.clk      (clk),
		.ctl      (min_ctl),
		.din      (link[NUM_STAGES]),
		.best     (best),
		.best_row (best_row)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (finish) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			rep_q  <= best;
			gidx_q <= best_row;
		end
	end

	assign out_valid      = out_valid_q;
	assign representative = rep_q;
	assign group_index    = gidx_q;

endmodule

// ===== hw/rtl/omr_cell.sv =====
// omr_cell: one delta swap stage of the Benes network with its own mask memory.
// Depends on omr_pkg. Two register stages: mask read, then swap.
module omr_cell #(
	parameter int MAX_GROUP = 256,
	parameter int STAGE_IDX = 0,
	parameter int SHIFT     = 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  omr_pkg::omr_load_t load,
	input  omr_pkg::omr_word_t din,
	output omr_pkg::omr_word_t dout
);
	import omr_pkg::*;

	localparam int AW = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1;

	logic [DATA_W-1:0] mem [MAX_GROUP];
	logic [DATA_W-1:0] mask_s1;
	logic [DATA_W-1:0] data_s1;
	logic [ROW_W-1:0]  row_s1;
	logic              valid_s1;
	logic [DATA_W-1:0] swap_bits;
	logic [DATA_W-1:0] swapped;
	logic              out_valid_s2;
	logic [ROW_W-1:0]  out_row_s2;
	logic [DATA_W-1:0] out_data_s2;

	always_ff @(posedge clk) begin
		if (load.we && load.stage == STAGE_W'(STAGE_IDX)) begin
			mem[AW'(load.row)] <= load.word;
		end
		mask_s1 <= mem[AW'(din.row)];
	end

	always_ff @(posedge clk) begin
		data_s1     <= din.data;
		row_s1      <= din.row;
		out_data_s2 <= swapped;
		out_row_s2  <= row_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1     <= 1'b0;
			out_valid_s2 <= 1'b0;
		end else begin
			valid_s1     <= din.valid;
			out_valid_s2 <= valid_s1;
		end
	end

	always_comb begin
		swap_bits = ((data_s1 >> SHIFT) ^ data_s1) & mask_s1;
		swapped   = data_s1 ^ swap_bits ^ (swap_bits << SHIFT);
	end

	assign dout = '{valid: out_valid_s2, row: out_row_s2, data: out_data_s2};

endmodule

// ===== hw/rtl/omr_min.sv =====
// omr_min: running minimum over the images leaving the last cell.
// Depends on omr_pkg. Keeps the first row on ties.
module omr_min (
	input  logic                      clk,
	input  omr_pkg::omr_min_ctl_t     ctl,
	input  omr_pkg::omr_word_t        din,
	output logic [omr_pkg::DATA_W-1:0] best,
	output logic [omr_pkg::ROW_W-1:0]  best_row
);
	import omr_pkg::*;

	logic [DATA_W-1:0] best_q;
	logic [ROW_W-1:0]  row_q;

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			best_q <= ctl.seed;
			row_q  <= '0;
		end else if (din.valid && din.data < best_q) begin
			best_q <= din.data;
			row_q  <= din.row;
		end
	end

	assign best     = best_q;
	assign best_row = row_q;

endmodule

// ===== hw/rtl/omr_checker.sv =====
// omr_checker: port level checks for orbit_min_representative, bound to the top.
// Depends on omr_pkg.
module omr_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         in_valid,
	input logic                         in_stall,
	input logic                         operation,
	input logic                         out_valid,
	input logic                         out_stall,
	input logic [omr_pkg::DATA_W-1:0]   representative,
	input logic [omr_pkg::ROW_W-1:0]    group_index
);
	import omr_pkg::*;

	// a held result keeps its word
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(representative)
			&& $stable(group_index))
		else $error("result changed while stalled");

	// a query takes the block off the input side
	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && operation == OP_QUERY |=> in_stall)
		else $error("input not stalled after query");

	// a load never makes a result appear
	a_load_silent: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && operation == OP_LOAD && !out_valid |=> !out_valid)
		else $error("result after load");

	// a result appears only at the end of a running query
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result without query");

endmodule

bind orbit_min_representative omr_checker u_omr_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_valid       (in_valid),
	.in_stall       (in_stall),
	.operation      (operation),
	.out_valid      (out_valid),
	.out_stall      (out_stall),
	.representative (representative),
	.group_index    (group_index)
);

// ===== tb/sv/orbit_min_representative_tb.sv =====
`timescale 1ns / 100ps
// orbit_min_representative_tb: self-checking bench for the orbit minimum representative block.
// Keeps its own permutation table and minimum search over the loaded rows.
// Depends on omr_pkg and orbit_min_representative.
module orbit_min_representative_tb;
	import omr_pkg::*;

	localparam int TABLE_ROWS = 256;

	typedef struct packed {
		logic               op;
		logic [ROW_W-1:0]   row;
		logic [STAGE_W-1:0] stage;
		logic [DATA_W-1:0]  word;
		logic [DATA_W-1:0]  state;
	} in_word_t;

	typedef struct packed {
		logic [DATA_W-1:0] state;
		logic [DATA_W-1:0] rep;
		logic [ROW_W-1:0]  idx;
	} orbit_result_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic               operation = OP_LOAD;
	logic [ROW_W-1:0]   mask_row = '0;
	logic [STAGE_W-1:0] mask_stage = '0;
	logic [DATA_W-1:0]  mask_word = '0;
	logic [DATA_W-1:0]  state_in = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic [DATA_W-1:0]  representative;
	logic [ROW_W-1:0]   group_index;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic [GC_W-1:0]    cfg_data = '0;

	// predictor copy of the block state
	logic [DATA_W-1:0] perm_masks [TABLE_ROWS][NUM_STAGES];
	logic [GC_W-1:0]   count_setting = GC_W'(1);
	// stimulus side: which mask entries have been queued for loading
	bit                mask_loaded [TABLE_ROWS][NUM_STAGES];

	in_word_t      pending_words[$];
	orbit_result_t expected_minima[$];
	in_word_t      next_word;
	orbit_result_t want;
	int            send_gap;
	int            stall_left;
	int            error_count;
	bit            burst_send;
	bit            burst_recv;

	orbit_min_representative #(
		.MAX_GROUP(TABLE_ROWS)
	) dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.operation     (operation),
		.mask_row      (mask_row),
		.mask_stage    (mask_stage),
		.mask_word     (mask_word),
		.state_in      (state_in),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.representative(representative),
		.group_index   (group_index),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	initial begin
		#20_000_000;
		$display("Regression FAIL");
		$finish;
	end

	function automatic int swap_distance(input int s);
		int d;
		case (s)
			0, 10: d = 1;
			1, 9: d = 2;
			2, 8: d = 4;
			3, 7: d = 8;
			4, 6: d = 16;
			default: d = 32;
		endcase
		return d;
	endfunction

	function automatic logic [DATA_W-1:0] delta_swap(input logic [DATA_W-1:0] x,
			input logic [DATA_W-1:0] m, input int d);
		logic [DATA_W-1:0] t;
		t = ((x >> d) ^ x) & m;
		return x ^ t ^ (t << d);
	endfunction

	function automatic logic [DATA_W-1:0] permute_state(input logic [DATA_W-1:0] x, input int row);
		logic [DATA_W-1:0] v;
		v = x;
		for (int s = 0; s < NUM_STAGES; s++) begin
			v = delta_swap(v, perm_masks[ROW_W'(row)][STAGE_W'(s)], swap_distance(s));
		end
		return v;
	endfunction

	// zero counts as one; cap at the table size and at what the index can hold
	function automatic int effective_count(input logic [GC_W-1:0] v);
		int n;
		n = (v == 0) ? 1 : int'(v);
		if (n > TABLE_ROWS) n = TABLE_ROWS;
		if (n > 256) n = 256;
		return n;
	endfunction

	function automatic orbit_result_t orbit_minimum(input logic [DATA_W-1:0] st);
		orbit_result_t res;
		logic [DATA_W-1:0] img;
		int n;
		n = effective_count(count_setting);
		res.state = st;
		res.rep = st;
		res.idx = '0;
		// strict compare: on a tie the lower row keeps the win
		for (int k = 1; k < n; k++) begin
			img = permute_state(st, k);
			if (img < res.rep) begin
				res.rep = img;
				res.idx = ROW_W'(k);
			end
		end
		return res;
	endfunction

	function automatic int gap_length();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 80);
	endfunction

	function automatic logic [DATA_W-1:0] random_word();
		return {$urandom, $urandom};
	endfunction

	function automatic logic [DATA_W-1:0] mask_pattern();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			2: return random_word() & random_word() & random_word();
			3: return 64'd1 << $urandom_range(0, 63);
			default: return random_word();
		endcase
	endfunction

	function automatic logic [DATA_W-1:0] state_pattern();
		case ($urandom_range(0, 11))
			0: return '0;
			1: return '1;
			2: return 64'd1 << $urandom_range(0, 63);
			3: return random_word() & random_word() & random_word();
			4: return random_word() | random_word() | random_word();
			5: return {32'd0, $urandom};
			default: return random_word();
		endcase
	endfunction

	task automatic flag_mismatch(input string msg);
		$display("mismatch: %s", msg);
		error_count++;
	endtask

	task automatic queue_load(input int row, input int stage, input logic [DATA_W-1:0] word);
		in_word_t w;
		w.op = OP_LOAD;
		w.row = ROW_W'(row);
		w.stage = STAGE_W'(stage);
		w.word = word;
		w.state = random_word();
		if (stage < NUM_STAGES) mask_loaded[ROW_W'(row)][STAGE_W'(stage)] = 1'b1;
		pending_words.push_back(w);
	endtask

	task automatic queue_query(input logic [DATA_W-1:0] st);
		in_word_t w;
		w.op = OP_QUERY;
		w.row = ROW_W'($urandom);
		w.stage = STAGE_W'($urandom);
		w.word = random_word();
		w.state = st;
		pending_words.push_back(w);
	endtask

	// load every entry that a query over n rows will read
	task automatic fill_rows(input int n);
		for (int r = 1; r < n; r++) begin
			for (int s = 0; s < NUM_STAGES; s++) begin
				if (!mask_loaded[ROW_W'(r)][STAGE_W'(s)]) queue_load(r, s, mask_pattern());
			end
		end
	endtask

	task automatic wait_idle();
		while (pending_words.size() != 0 || in_valid || expected_minima.size() != 0) begin
			@(posedge clk);
		end
	endtask

	task automatic program_count(input logic [GC_W-1:0] v);
		wait_idle();
		repeat (DRAIN_CYCLES + 10) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		cfg_data <= GC_W'($urandom);
		count_setting = v;
	endtask

	// driver: accept, predict, then present the next word
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			send_gap <= 0;
		end else begin
			if (in_valid && !in_stall) begin
				if (operation == OP_LOAD) begin
					if (mask_stage < NUM_STAGES && mask_row < TABLE_ROWS)
						perm_masks[mask_row][mask_stage] = mask_word;
				end else begin
					expected_minima.push_back(orbit_minimum(state_in));
				end
			end
			if (!in_valid || !in_stall) begin
				if (send_gap != 0 || pending_words.size() == 0) begin
					in_valid <= 1'b0;
					if (send_gap != 0) send_gap <= send_gap - 1;
				end else begin
					next_word = pending_words.pop_front();
					in_valid <= 1'b1;
					operation <= next_word.op;
					mask_row <= next_word.row;
					mask_stage <= next_word.stage;
					mask_word <= next_word.word;
					state_in <= next_word.state;
					send_gap <= burst_send ? 0 : gap_length();
				end
			end
		end
	end

	// monitor: check each accepted result, then pick the next stall
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			stall_left <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_minima.size() == 0) begin
					flag_mismatch($sformatf("unexpected result %h / %0d",
						representative, group_index));
				end else begin
					want = expected_minima.pop_front();
					if (representative !== want.rep)
						flag_mismatch($sformatf("state %h: representative %h, want %h",
							want.state, representative, want.rep));
					if (group_index !== want.idx)
						flag_mismatch($sformatf("state %h: group_index %0d, want %0d",
							want.state, group_index, want.idx));
				end
			end
			if (stall_left > 0) begin
				out_stall <= 1'b1;
				stall_left <= stall_left - 1;
			end else if (!burst_recv && $urandom_range(0, 3) == 0) begin
				out_stall <= 1'b1;
				stall_left <= gap_length();
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	initial begin
		logic [DATA_W-1:0] m;
		logic [GC_W-1:0] gc;
		int n;
		int items;
		int r;

		error_count = 0;
		burst_send = 1'b0;
		burst_recv = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// identity only after reset; out-of-range stages are dropped, row 0 is never read
		queue_query('0);
		queue_query('1);
		queue_query(random_word());
		queue_load(0, 0, '1);
		queue_load(7, NUM_STAGES, random_word());
		queue_load(9, 15, random_word());
		queue_load(TABLE_ROWS - 1, NUM_STAGES - 1, random_word());

		// rows 1 and 2 identical: a tie must keep the lower row
		program_count(GC_W'(3));
		for (int s = 0; s < NUM_STAGES; s++) begin
			m = random_word();
			queue_load(1, s, m);
			queue_load(2, s, m);
		end
		queue_query('0);
		queue_query('1);
		queue_query(64'h8000_0000_0000_0000);
		queue_query(random_word());
		queue_query(random_word());

		program_count('0);
		queue_query(random_word());
		queue_query(random_word());

		for (int p = 0; p < 20; p++) begin
			case (p)
				3: gc = GC_W'(40);
				7: gc = '0;
				12: gc = GC_W'(1);
				19: gc = GC_W'(2);
				default: gc = GC_W'($urandom_range(2, 40));
			endcase
			program_count(gc);
			n = effective_count(gc);
			burst_send = ($urandom_range(0, 3) == 0);
			burst_recv = ($urandom_range(0, 3) == 0);
			fill_rows(n);
			items = 35;
			for (int i = 0; i < items; i++) begin
				r = $urandom_range(0, 99);
				if (r < 60) begin
					queue_query(state_pattern());
				end else if (r < 85) begin
					queue_load((n > 1) ? $urandom_range(1, n - 1) : 0,
						$urandom_range(0, NUM_STAGES - 1), mask_pattern());
				end else if (r < 93) begin
					queue_load($urandom_range(0, TABLE_ROWS - 1),
						$urandom_range(0, NUM_STAGES - 1), mask_pattern());
				end else begin
					queue_load($urandom_range(0, TABLE_ROWS - 1),
						$urandom_range(NUM_STAGES, 15), random_word());
				end
			end
		end

		wait_idle();
		repeat (64) @(posedge clk);
		if (error_count == 0 && expected_minima.size() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
hw/rtl/omr_pkg.sv
hw/rtl/omr_cell.sv
hw/rtl/omr_min.sv
hw/rtl/orbit_min_representative.sv
hw/rtl/omr_checker.sv
tb/sv/orbit_min_representative_tb.sv
